// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator modules.
// Depends on nothing; included by each file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define FISA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define FISA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fisa_pkg.sv =====
// Shared types and constants for the free index stack allocator.
// Depends on nothing.
package fisa_pkg;

	localparam int NUM_SLOTS  = 1024;
	localparam int MAX_BATCH  = 64;
	localparam int SLOT_W     = 10;
	localparam int COUNT_W    = 7;
	localparam int ADDR_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W      = FIFO_CNT_W + 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANT    = 2'd0,
		ST_REFUSE   = 2'd1,
		ST_FREED    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} rsp_t;

endpackage

// ===== design/fisa_stack_ram.sv =====
// Single write port, single read port RAM holding the free index stack.
// Read data is registered. No dependencies.
module fisa_stack_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/fisa_result_fifo.sv =====
// Small result queue between the stack pipeline and the result channel.
// Depends on fisa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fisa_result_fifo
	import fisa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rsp_t                  push_data,
	output logic [FIFO_CNT_W-1:0] fill,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp_data
);

	rsp_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign pop       = rsp_valid && !rsp_stall;
	assign rsp_valid = (count_q != '0);
	assign rsp_data  = entry_q[rd_ptr_q];
	assign fill      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`FISA_ASSERT(a_no_push_full, clk, arst_n, (count_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> !push, "result queue overrun")
	`FISA_ASSERT(a_fill_bound, clk, arst_n, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue fill out of range")
	`FISA_ASSERT(a_pop_drains, clk, arst_n, (pop && !push) |=> (count_q == $past(count_q) - FIFO_CNT_W'(1)), "result queue fill not reduced on pop")

endmodule

// ===== design/free_index_stack_allocator.sv =====
// Top level of the free index stack allocator: control, stack RAM, result queue.
// Depends on fisa_pkg, fisa_stack_ram, fisa_result_fifo and assert_macros.svh.
//
//  channel | handshake            | fields
//  req     | req_valid, req_stall | command, count, index
//  rsp     | rsp_valid, rsp_stall | status, slot, last
//
// A granted allocate of n indices holds the request side while it takes the beat and then
// issues one stack RAM read per granted index (single read port).
// Free, refused allocate and overflow are answered with a single result each.
// Reset leaves the stack RAM untouched: a low-water mark of the fill count marks which
// entries were never written, and those read back as their own position.
// A stalled result channel pauses the reads once the result queue is full.
`include "assert_macros.svh"

module free_index_stack_allocator
	import fisa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               command,
	input  logic [COUNT_W-1:0] count,
	input  logic [SLOT_W-1:0]  index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot,
	output logic               last
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_ALLOC = 2'b10
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      free_count_q;
	logic [CNT_W-1:0]      low_mark_q;
	logic [CNT_W-1:0]      batch_mark_q;
	logic [CNT_W-1:0]      pos_q;
	logic [COUNT_W-1:0]    rem_q;

	logic                  vld_s1;
	logic                  rd_s1;
	logic                  unwr_s1;
	status_t               status_s1;
	logic [SLOT_W-1:0]     pos_s1;
	logic                  last_s1;

	logic [FIFO_CNT_W-1:0] fill;
	logic [OCC_W-1:0]      occupancy;
	logic                  room;
	logic                  accept;
	logic                  alloc_ok;
	logic                  stack_full;
	logic [CNT_W-1:0]      new_count;
	logic                  issue;
	logic                  wr_en;
	logic [SLOT_W-1:0]     rd_data;
	rsp_t                  push_data;
	rsp_t                  rsp_data;

	// Count the beat in stage 1 so a result can never overrun the queue.
	assign occupancy  = OCC_W'(fill) + OCC_W'(vld_s1);
	assign room       = occupancy < OCC_W'(FIFO_DEPTH);
	assign req_stall  = (state_q != S_IDLE) || !room;
	assign accept     = req_valid && !req_stall;

	assign alloc_ok   = (count != '0) && (count <= COUNT_W'(MAX_BATCH))
	                    && (CMP_W'(count) <= CMP_W'(free_count_q));
	assign new_count  = free_count_q - CNT_W'(count);
	assign stack_full = free_count_q >= CNT_W'(NUM_SLOTS);
	assign issue      = (state_q == S_ALLOC) && room;
	assign wr_en      = accept && (command == CMD_FREE) && !stack_full;

	fisa_stack_ram #(
		.DEPTH (NUM_SLOTS),
		.WIDTH (SLOT_W)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(free_count_q)),
		.wr_data (index),
		.rd_en   (issue),
		.rd_addr (ADDR_W'(pos_q)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_count_q <= CNT_W'(NUM_SLOTS);
			low_mark_q   <= CNT_W'(NUM_SLOTS);
			batch_mark_q <= CNT_W'(NUM_SLOTS);
			pos_q        <= '0;
			rem_q        <= '0;
			vld_s1       <= 1'b0;
			rd_s1        <= 1'b0;
		end else begin
			// A granted allocate produces nothing until its reads are issued.
			vld_s1 <= (accept && !((command == CMD_ALLOC) && alloc_ok)) || issue;
			rd_s1  <= issue;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_ALLOC) begin
							if (alloc_ok) begin
								free_count_q <= new_count;
								pos_q        <= new_count;
								rem_q        <= count;
								batch_mark_q <= low_mark_q;
								if (new_count < low_mark_q) begin
									low_mark_q <= new_count;
								end
								state_q <= S_ALLOC;
							end
						end else if (!stack_full) begin
							free_count_q <= free_count_q + CNT_W'(1);
						end
					end
				end
				S_ALLOC: begin
					if (issue) begin
						pos_q  <= pos_q + CNT_W'(1);
						rem_q  <= rem_q - COUNT_W'(1);
						if (rem_q == COUNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Stage 1 payload: result code and the position whose RAM data arrives in the same cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= 1'b1;
			unwr_s1 <= 1'b0;
			pos_s1  <= '0;
			if (command == CMD_ALLOC) begin
				status_s1 <= ST_REFUSE;
			end else if (stack_full) begin
				status_s1 <= ST_OVERFLOW;
			end else begin
				status_s1 <= ST_FREED;
			end
		end else if (issue) begin
			status_s1 <= ST_GRANT;
			last_s1   <= (rem_q == COUNT_W'(1));
			unwr_s1   <= (pos_q < batch_mark_q);
			pos_s1    <= SLOT_W'(pos_q);
		end
	end

	// Entries below the low-water mark were never written: their position is returned instead.
	always_comb begin
		push_data.status = status_s1;
		push_data.last   = last_s1;
		if (!rd_s1) begin
			push_data.slot = '0;
		end else if (unwr_s1) begin
			push_data.slot = pos_s1;
		end else begin
			push_data.slot = rd_data;
		end
	end

	fisa_result_fifo u_results (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s1),
		.push_data (push_data),
		.fill      (fill),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	assign status = rsp_data.status;
	assign slot   = rsp_data.slot;
	assign last   = rsp_data.last;

	`FISA_ASSERT(a_count_bound, clk, arst_n, free_count_q <= CNT_W'(NUM_SLOTS), "free count above pool size")
	`FISA_ASSERT(a_mark_bound, clk, arst_n, low_mark_q <= free_count_q, "low-water mark above free count")
	`FISA_ASSERT(a_batch_live, clk, arst_n, (state_q == S_ALLOC) |-> (rem_q != '0), "batch running with nothing left")
	`FISA_ASSERT(a_write_idle, clk, arst_n, wr_en |-> !issue, "stack write overlaps a batch read")
	`FISA_ASSERT_ALWAYS(a_reset_full, clk, !arst_n |=> (free_count_q == CNT_W'(NUM_SLOTS)), "stack not full in reset")

endmodule
